[hdl/gpiorb_pkg.sv]
// Package for the GPIO register block: request and response beat types,
// access codes and fixed register-map constants.
// Depends on nothing; every other file of the block imports it.
package gpiorb_pkg;

  localparam int PinSlots      = 64;
  localparam int PinsPerSelect = 10;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } command_e;

  localparam logic [2:0] FSEL_OUTPUT = 3'd1;
  localparam logic [1:0] PULL_DOWN   = 2'd1;
  localparam logic [1:0] PULL_UP     = 2'd2;

  typedef struct packed {
    logic        command;
    logic [5:0]  word_index;
    logic [31:0] write_data;
    logic [63:0] pin_levels;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [63:0] drive_levels;
    logic [63:0] output_enables;
    logic [63:0] pull_up_mask;
    logic [63:0] pull_down_mask;
  } rsp_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_SELECT,
    ACC_SET,
    ACC_CLEAR,
    ACC_LEVEL,
    ACC_MODE,
    ACC_CLOCK
  } access_e;

  typedef struct packed {
    access_e kind;
    logic    half;
  } decode_t;

endpackage

[hdl/gpiorb_decode.sv]
// Address decoder of the GPIO register block: maps a word offset to the
// register it hits and the 32-pin half it covers. Depends on gpiorb_pkg.
module gpiorb_decode import gpiorb_pkg::*; #(
  parameter int NUM_PINS        = 64,
  parameter int SET_WORD        = 7,
  parameter int CLEAR_WORD      = 10,
  parameter int LEVEL_WORD      = 13,
  parameter int PULL_MODE_WORD  = 37,
  parameter int PULL_CLOCK_WORD = 38
) (
  input  logic [5:0] word_i,
  output decode_t    dec_o
);

  localparam logic [6:0] SelectWords =
    7'((NUM_PINS + PinsPerSelect - 1) / PinsPerSelect);

  logic [6:0] word;

  assign word = {1'b0, word_i};

  // The map order decides where parameters make two entries share a word.
  always_comb begin
    dec_o = '{kind: ACC_NONE, half: 1'b0};
    priority if (word < SelectWords) begin
      dec_o.kind = ACC_SELECT;
    end else if (word == 7'(SET_WORD) || word == 7'(SET_WORD + 1)) begin
      dec_o.kind = ACC_SET;
      dec_o.half = (word != 7'(SET_WORD));
    end else if (word == 7'(CLEAR_WORD) || word == 7'(CLEAR_WORD + 1)) begin
      dec_o.kind = ACC_CLEAR;
      dec_o.half = (word != 7'(CLEAR_WORD));
    end else if (word == 7'(LEVEL_WORD) || word == 7'(LEVEL_WORD + 1)) begin
      dec_o.kind = ACC_LEVEL;
      dec_o.half = (word != 7'(LEVEL_WORD));
    end else if (word == 7'(PULL_MODE_WORD)) begin
      dec_o.kind = ACC_MODE;
    end else if (word == 7'(PULL_CLOCK_WORD) || word == 7'(PULL_CLOCK_WORD + 1)) begin
      dec_o.kind = ACC_CLOCK;
      dec_o.half = (word != 7'(PULL_CLOCK_WORD));
    end else begin
      dec_o.kind = ACC_NONE;
    end
  end

endmodule

[hdl/gpio_register_block.sv]
// A beat accepted into the input register passes through decode and state update
// into the result register, which raises the done_o strobe and drives rsp_o.
// Throughput: one beat per cycle; busy never rises, and the single pass of
// decode and state update between the two registers sets this figure.
// Reset clears all pin state, the pull registers and the pipeline valid bits.
// The receiver cannot stall: done_o is high for a single cycle, and rsp_o holds to the next result.
// Top level of the GPIO register block. Depends on gpiorb_pkg and gpiorb_decode.
module gpio_register_block import gpiorb_pkg::*; #(
  parameter int NUM_PINS        = 64,
  parameter int SET_WORD        = 7,
  parameter int CLEAR_WORD      = 10,
  parameter int LEVEL_WORD      = 13,
  parameter int PULL_MODE_WORD  = 37,
  parameter int PULL_CLOCK_WORD = 38
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  // Pins beyond NUM_PINS never show up on a 64-bit pin vector.
  localparam logic [63:0] PinMask =
    (NUM_PINS >= PinSlots) ? '1 : ((64'd1 << NUM_PINS) - 64'd1);

  // Input register: holds the accepted beat while it is decoded.
  logic    valid_q;
  req_t    req_q;
  decode_t dec;

  // Architectural state of the register map.
  logic [2:0]          fsel_q   [NUM_PINS];
  logic [2:0]          fsel_d   [NUM_PINS];
  logic [1:0]          pull_q   [NUM_PINS];
  logic [1:0]          pull_d   [NUM_PINS];
  logic [NUM_PINS-1:0] latch_q, latch_d;
  logic [1:0]          mode_q, mode_d;
  logic [31:0]         clock_q  [2];
  logic [31:0]         clock_d  [2];

  // Result register.
  logic done_q;
  rsp_t rsp_q, rsp_d;

  logic                is_write;
  logic [63:0]         data_pins;
  logic [63:0]         rise_pins;
  logic [31:0]         rise_half;
  logic [63:0]         levels;
  logic [31:0]         fsel_rd_term [NUM_PINS];
  logic [31:0]         fsel_rd;
  logic [31:0]         rd;
  logic [NUM_PINS-1:0] oe_d, up_d, down_d;

  // A new beat is welcome in every cycle.
  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
  end

  gpiorb_decode #(
    .NUM_PINS        (NUM_PINS),
    .SET_WORD        (SET_WORD),
    .CLEAR_WORD      (CLEAR_WORD),
    .LEVEL_WORD      (LEVEL_WORD),
    .PULL_MODE_WORD  (PULL_MODE_WORD),
    .PULL_CLOCK_WORD (PULL_CLOCK_WORD)
  ) u_decode (
    .word_i (req_q.word_index),
    .dec_o  (dec)
  );

  assign is_write = valid_q && (req_q.command == CMD_WRITE);

  // Written data placed on the half of the pin vector that the word covers.
  assign data_pins = dec.half ? {req_q.write_data, 32'd0} : {32'd0, req_q.write_data};

  // Only bits that go from zero to one in the pull clock word latch the mode.
  assign rise_half = req_q.write_data & ~clock_q[dec.half];
  assign rise_pins = dec.half ? {rise_half, 32'd0} : {32'd0, rise_half};

  assign levels = req_q.pin_levels & PinMask;

  // Each pin sits at a fixed word and slot of the function-select map, so
  // its write enable and its read-back term are worked out per pin.
  for (genvar p = 0; p < NUM_PINS; p++) begin : g_pin
    localparam int Word = p / PinsPerSelect;
    localparam int Slot = p % PinsPerSelect;

    logic word_hit;

    assign word_hit = (dec.kind == ACC_SELECT) && (req_q.word_index == 6'(Word));

    assign fsel_d[p] = (is_write && word_hit) ? req_q.write_data[3*Slot +: 3] : fsel_q[p];

    assign fsel_rd_term[p] = word_hit ? ({29'd0, fsel_q[p]} << (3 * Slot)) : 32'd0;

    assign oe_d[p]   = (fsel_d[p] == FSEL_OUTPUT);
    assign up_d[p]   = (pull_d[p] == PULL_UP);
    assign down_d[p] = (pull_d[p] == PULL_DOWN);
  end

  always_comb begin
    fsel_rd = 32'd0;
    for (int p = 0; p < NUM_PINS; p++) begin
      fsel_rd = fsel_rd | fsel_rd_term[p];
    end
  end

  // Next state of the latch and pull registers.
  always_comb begin
    latch_d = latch_q;
    mode_d  = mode_q;
    clock_d = clock_q;
    pull_d  = pull_q;
    if (is_write) begin
      unique case (dec.kind)
        ACC_SET: begin
          latch_d = latch_q | data_pins[NUM_PINS-1:0];
        end
        ACC_CLEAR: begin
          latch_d = latch_q & ~data_pins[NUM_PINS-1:0];
        end
        ACC_MODE: begin
          mode_d = req_q.write_data[1:0];
        end
        ACC_CLOCK: begin
          clock_d[dec.half] = req_q.write_data;
          for (int p = 0; p < NUM_PINS; p++) begin
            if (rise_pins[p]) begin
              pull_d[p] = mode_q;
            end
          end
        end
        default: begin
          latch_d = latch_q;
        end
      endcase
    end
  end

  // Read data; set and clear words and unknown words read as zero.
  always_comb begin
    rd = 32'd0;
    unique case (dec.kind)
      ACC_SELECT: rd = fsel_rd;
      ACC_LEVEL:  rd = dec.half ? levels[63:32] : levels[31:0];
      ACC_MODE:   rd = {30'd0, mode_q};
      ACC_CLOCK:  rd = clock_q[dec.half];
      default:    rd = 32'd0;
    endcase
  end

  // The result shows the state after the access.
  always_comb begin
    rsp_d.read_data      = (req_q.command == CMD_WRITE) ? 32'd0 : rd;
    rsp_d.drive_levels   = 64'(latch_d);
    rsp_d.output_enables = 64'(oe_d);
    rsp_d.pull_up_mask   = 64'(up_d);
    rsp_d.pull_down_mask = 64'(down_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsel_q  <= '{default: '0};
      pull_q  <= '{default: '0};
      latch_q <= '0;
      mode_q  <= '0;
      clock_q <= '{default: '0};
      done_q  <= 1'b0;
    end else begin
      fsel_q  <= fsel_d;
      pull_q  <= pull_d;
      latch_q <= latch_d;
      mode_q  <= mode_d;
      clock_q <= clock_d;
      done_q  <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Every beat in the input register is answered in the next cycle.
  a_beat_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> done_o)
    else $error("accepted beat produced no result");

  // A write never returns read data.
  a_write_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && req_q.command == CMD_WRITE) |=> (rsp_o.read_data == 32'd0))
    else $error("write beat returned non-zero read data");

  // Reads and idle cycles leave the output latch alone.
  a_latch_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !is_write |=> $stable(latch_q))
    else $error("output latch changed without a write");

  // A set write only adds ones to the latch.
  a_set_only_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_write && dec.kind == ACC_SET) |=> ((latch_q & $past(latch_q)) == $past(latch_q)))
    else $error("set write cleared a latch bit");

  // Without a pull clock write the pull-up mask does not move.
  a_pull_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !$past(is_write && dec.kind == ACC_CLOCK, 1) && $past(done_o))
      |-> (rsp_o.pull_up_mask == $past(rsp_o.pull_up_mask)))
    else $error("pull-up mask changed without a pull clock write");

endmodule
